>>> sv/rld_pkg.sv
// Shared types, constants and ring helpers for the run-length deque.
package rld_pkg;

	localparam int MAX_RUNS = 64;
	localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int OCC_W = $clog2(MAX_RUNS + 1);
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// command codes
	localparam logic [2:0] FN_PUSH_FRONT  = 3'd0;
	localparam logic [2:0] FN_PUSH_BACK   = 3'd1;
	localparam logic [2:0] FN_POP_FRONT   = 3'd2;
	localparam logic [2:0] FN_POP_BACK    = 3'd3;
	localparam logic [2:0] FN_QUERY_FRONT = 3'd4;
	localparam logic [2:0] FN_QUERY_BACK  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	typedef struct packed {
		logic [2:0]              func;
		logic signed [VAL_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] run_length;
	} rsp_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
	} run_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;  // capture command, launch ring read
		logic exec;  // apply command, write back, load result
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // result register can take a new result
	} dp_stat_t;

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
		ring_inc = (i == IDX_W'(MAX_RUNS - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
		ring_dec = (i == '0) ? IDX_W'(MAX_RUNS - 1) : i - IDX_W'(1);
	endfunction

	function automatic logic is_front(input logic [2:0] f);
		is_front = (f == FN_PUSH_FRONT) || (f == FN_POP_FRONT) || (f == FN_QUERY_FRONT);
	endfunction

endpackage

>>> sv/rld_ctrl.sv
// Controller state machine: command capture and execute sequencing.
module rld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  rld_pkg::dp_stat_t stat,
	output rld_pkg::ctl_cmd_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register is free
				if (stat.out_free) begin
					ctl.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/rld_dp.sv
// Datapath: run ring memory, end pointers, occupancy and result register.
module rld_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  rld_pkg::cmd_item_t cmd,
	input  rld_pkg::ctl_cmd_t  ctl,
	output rld_pkg::dp_stat_t  stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rld_pkg::rsp_item_t rsp
);

	localparam int IDX_W = rld_pkg::IDX_W;
	localparam int OCC_W = rld_pkg::OCC_W;
	localparam int VAL_W = rld_pkg::VAL_W;
	localparam int CNT_W = rld_pkg::CNT_W;

	rld_pkg::run_entry_t ring_mem [rld_pkg::MAX_RUNS];
	rld_pkg::run_entry_t rd_q;

	logic [IDX_W-1:0] head_q, tail_q, end_q;
	logic [OCC_W-1:0] occ_q;
	logic [2:0]       func_q;
	logic [VAL_W-1:0] value_q;

	logic [IDX_W-1:0]    rd_addr, wr_addr, new_idx, head_d, tail_d;
	logic [OCC_W-1:0]    occ_d;
	logic                wr_en, front, occ_empty, occ_full;
	rld_pkg::run_entry_t wr_data;
	rld_pkg::rsp_item_t  res;
	logic                rsp_valid_q;
	rld_pkg::rsp_item_t  rsp_q;

	assign rd_addr   = rld_pkg::is_front(cmd.func) ? head_q : tail_q;
	assign front     = rld_pkg::is_front(func_q);
	assign occ_empty = (occ_q == '0);
	assign occ_full  = (occ_q == OCC_W'(rld_pkg::MAX_RUNS));
	assign new_idx   = front ? rld_pkg::ring_dec(head_q) : rld_pkg::ring_inc(tail_q);

	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = end_q;
		wr_data.value  = value_q;
		wr_data.count  = CNT_W'(1);
		head_d         = head_q;
		tail_d         = tail_q;
		occ_d          = occ_q;
		res.status     = rld_pkg::ST_OK;
		res.run_length = '0;
		case (func_q) inside
			rld_pkg::FN_PUSH_FRONT, rld_pkg::FN_PUSH_BACK: begin
				if (occ_empty) begin
					wr_en   = 1'b1;
					wr_addr = head_q;
					tail_d  = head_q;
					occ_d   = OCC_W'(1);
				end else if (rd_q.value == value_q) begin
					if (rd_q.count == rld_pkg::COUNT_MAX) begin
						res.status = rld_pkg::ST_SAT;
					end else begin
						wr_en         = 1'b1;
						wr_data.count = rd_q.count + CNT_W'(1);
					end
				end else if (occ_full) begin
					res.status = rld_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = new_idx;
					occ_d   = occ_q + OCC_W'(1);
					if (front) begin
						head_d = new_idx;
					end else begin
						tail_d = new_idx;
					end
				end
			end
			rld_pkg::FN_POP_FRONT, rld_pkg::FN_POP_BACK: begin
				if (occ_empty) begin
					res.status = rld_pkg::ST_EMPTY;
				end else if (rd_q.count > CNT_W'(1)) begin
					wr_en         = 1'b1;
					wr_data.value = rd_q.value;
					wr_data.count = rd_q.count - CNT_W'(1);
				end else begin
					occ_d = occ_q - OCC_W'(1);
					// last run gone: pointers stay put
					if (occ_q != OCC_W'(1)) begin
						if (front) begin
							head_d = rld_pkg::ring_inc(head_q);
						end else begin
							tail_d = rld_pkg::ring_dec(tail_q);
						end
					end
				end
			end
			default: begin
				// queries; unused codes read the back run
				if (!occ_empty) begin
					res.run_length = rd_q.count;
				end
			end
		endcase
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		if (ctl.load) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			func_q  <= cmd.func;
			value_q <= cmd.value;
			end_q   <= rd_addr;
		end
		if (ctl.exec) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				head_q <= head_d;
				tail_q <= tail_d;
				occ_q  <= occ_d;
			end
			if (ctl.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

>>> sv/run_length_deque.sv
// A command is taken in idle, where the registered ring read is launched, and is
// applied in execute, where the touched run is written back to the ring; no new
// command is taken until the previous one has executed.
// A result that waits on rsp_stall holds the next command in execute.
// Reset (arst_n low) clears the end pointers, run occupancy, FSM and result
// valid; ring contents are not cleared and only occupied runs are used.
module run_length_deque (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  rld_pkg::cmd_item_t cmd,
	// result channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rld_pkg::rsp_item_t rsp
);

	// controller <-> datapath
	rld_pkg::ctl_cmd_t ctl_cmd;
	rld_pkg::dp_stat_t dp_stat;

	// Controller: idle takes a transfer and launches the ring read;
	// execute applies the command once the result register is free.
	rld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (dp_stat),
		.ctl       (ctl_cmd)
	);

	// Datapath: the ring of (value, count) runs, head/tail pointers,
	// occupancy, and the result register that decouples the two sides.
	rld_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl_cmd),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	// a captured command blocks the channel until it has executed
	a_load_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.load |=> cmd_stall)
		else $error("command transfer taken while previous one in flight");

	// every execute produces a visible result
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.exec |=> rsp_valid)
		else $error("executed command produced no result");

	// a taken result is not repeated unless a new one was executed
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && !ctl_cmd.exec) |=> !rsp_valid)
		else $error("result repeated after transfer");
`endif

endmodule
